// ===== rtl/ttt_pkg.sv =====
// shared types, constants and a helper function of the traffic target table
// no dependencies
`default_nettype none
package ttt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam logic [23:0] ADDR_LOW_MASK = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_AGE_OUT = 2'd1,
    OP_ALARM   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_UPDATED     = 3'd0,
    ST_KEPT_OLDER  = 3'd1,
    ST_INSERTED    = 3'd2,
    ST_OWN_SHIP    = 3'd3,
    ST_IMPLAUSIBLE = 3'd4,
    ST_FULL        = 3'd5,
    ST_OTHER_DONE  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PL_PLAUSIBLE = 2'd0,
    PL_TOO_FAR   = 2'd1,
    PL_NO_REF    = 2'd2,
    PL_UNKNOWN   = 2'd3
  } plaus_e;

  typedef enum logic [1:0] {
    CFG_OWN_ADDR  = 2'd0,
    CFG_OWN_TABLE = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_MAX_AGE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FINISH
  } state_e;

  // one table entry as held in the ram
  typedef struct packed {
    logic [7:0]  key_table;
    logic [31:0] key_addr;
    logic [31:0] time_s;
    logic [1:0]  rank;
    logic [30:0] slant;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // field order follows {tuser, tdata} from the top bit down
  typedef struct packed {
    op_e         op;
    logic        alarm_mark;
    logic [3:0]  slot;
    logic [30:0] slant_m;
    logic [1:0]  plausibility;
    logic [31:0] now_s;
    logic [31:0] obs_time_s;
    logic [1:0]  src_rank;
    logic [31:0] addr;
    logic [7:0]  tgt_table;
  } item_t;

  // findings of one pass over the table
  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic [31:0]      match_time;
    logic [1:0]       match_rank;
    logic             best_found;
    logic [IDX_W-1:0] best_idx;
    logic [30:0]      best_slant;
    logic [1:0]       best_rank;
    logic [31:0]      best_age;
  } scan_t;

  // true when weight a matters less than weight b
  function automatic logic less_important(
    input logic [30:0] sa, input logic [1:0] ra, input logic [31:0] aa,
    input logic [30:0] sb, input logic [1:0] rb, input logic [31:0] ab);
    logic r;
    if (sa != sb) begin
      r = sa > sb;
    end else if (ra != rb) begin
      r = ra < rb;
    end else begin
      r = aa > ab;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ttt_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module ttt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ttt_scan.sv =====
// per-entry evaluation during a pass: key match, eviction candidate, expiry
// depends on ttt_pkg
`default_nettype none
module ttt_scan (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic                      vld_i,
  input  wire logic [ttt_pkg::IDX_W-1:0] idx_i,
  input  wire logic                      used_i,
  input  wire logic                      alarm_i,
  input  wire ttt_pkg::entry_t           entry_i,
  input  wire logic [7:0]                key_table_i,
  input  wire logic [31:0]               key_addr_i,
  input  wire logic [31:0]               now_i,
  input  wire logic [31:0]               max_age_i,
  output ttt_pkg::scan_t                 res_o,
  output logic                           expire_o
);

  ttt_pkg::scan_t res_d, res_q;
  logic [31:0] age;
  logic        hit;

  assign age = now_i - entry_i.time_s;
  assign hit = vld_i && used_i && (entry_i.key_addr == key_addr_i)
               && (entry_i.key_table == key_table_i);
  assign expire_o = vld_i && used_i && (age > max_age_i);

  always_comb begin
    res_d = res_q;
    if (clear_i) begin
      res_d.match_found = 1'b0;
      res_d.best_found  = 1'b0;
    end else if (vld_i) begin
      // first matching key wins
      if (hit && !res_q.match_found) begin
        res_d.match_found = 1'b1;
        res_d.match_idx   = idx_i;
        res_d.match_time  = entry_i.time_s;
        res_d.match_rank  = entry_i.rank;
      end
      // least important unmarked slot, earliest on ties
      if (used_i && !alarm_i && (!res_q.best_found ||
          ttt_pkg::less_important(entry_i.slant, entry_i.rank, age,
                                  res_q.best_slant, res_q.best_rank, res_q.best_age))) begin
        res_d.best_found = 1'b1;
        res_d.best_idx   = idx_i;
        res_d.best_slant = entry_i.slant;
        res_d.best_rank  = entry_i.rank;
        res_d.best_age   = age;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

// ===== rtl/traffic_target_table_unit.sv =====
// traffic target table: observation, age-out, alarm and clear transactions
// order: observation and age-out first scan every slot, one ram read per slot,
//   then decide and finish; alarm and clear go straight to decide and finish
// flow: one transaction at a time; the next is taken the cycle after the
//   result is queued, and queuing waits while the output stream stalls
// reset: slot used and alarm marks and the refusal counter clear at once,
//   config goes to its defaults; ram contents are not cleared
`default_nettype none
module traffic_target_table_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // slave stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // tgt_table[7:0], addr[39:8], src_rank[41:40], obs_time_s[73:42],
  // now_s[105:74], plausibility[107:106], slant_m[138:108], slot[142:139],
  // alarm_mark[143]
  input  wire logic [143:0]  s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  // master stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // slot_index[3:0], occupied[8:4], removed[13:9], implausible_count[45:14], zero[47:46]
  output logic [47:0]        m_axis_tdata,
  // status[2:0]
  output logic [2:0]         m_axis_tuser,
  // config write port
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_wdata_i
);

  localparam int unsigned CAP   = ttt_pkg::CAPACITY;
  localparam int unsigned IDX_W = ttt_pkg::IDX_W;
  localparam int unsigned CNT_W = ttt_pkg::CNT_W;

  // config registers
  logic [23:0] own_addr_q;
  logic [7:0]  own_table_q;
  logic [15:0] hold_q;
  logic [31:0] max_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= '0;
      own_table_q <= '0;
      hold_q      <= 16'd3;
      max_age_q   <= 32'd20;
    end else if (cfg_we_i) begin
      unique case (ttt_pkg::cfg_idx_e'(cfg_idx_i))
        ttt_pkg::CFG_OWN_ADDR:  own_addr_q  <= cfg_wdata_i[23:0];
        ttt_pkg::CFG_OWN_TABLE: own_table_q <= cfg_wdata_i[7:0];
        ttt_pkg::CFG_HOLD:      hold_q      <= cfg_wdata_i[15:0];
        ttt_pkg::CFG_MAX_AGE:   max_age_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control state
  ttt_pkg::state_e  state_q, state_d;
  ttt_pkg::item_t   item_q, item_d;
  logic [CAP-1:0]   used_q, used_d;
  logic [CAP-1:0]   alarm_q, alarm_d;
  logic [31:0]      refusals_q, refusals_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             proc_vld_q, proc_vld_d;
  logic [IDX_W-1:0] proc_idx_q, proc_idx_d;
  logic [CNT_W-1:0] removed_q, removed_d;
  ttt_pkg::status_e status_q, status_d;
  logic [IDX_W-1:0] slot_res_q, slot_res_d;
  logic             out_vld_q, out_vld_d;
  logic [47:0]      out_data_q, out_data_d;
  logic [2:0]       out_user_q, out_user_d;

  // ram and scan wiring
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  ttt_pkg::entry_t  ram_wdata, ram_rdata;
  ttt_pkg::scan_t   scan;
  logic             scan_clear, expire;

  localparam int unsigned ENTRY_W_L = ttt_pkg::ENTRY_W;
  logic [ENTRY_W_L-1:0] ram_rbits;

  ttt_ram #(
    .WIDTH (ENTRY_W_L),
    .DEPTH (CAP)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rbits)
  );

  assign ram_rdata = ttt_pkg::entry_t'(ram_rbits);

  ttt_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (scan_clear),
    .vld_i       (proc_vld_q),
    .idx_i       (proc_idx_q),
    .used_i      (used_q[proc_idx_q]),
    .alarm_i     (alarm_q[proc_idx_q]),
    .entry_i     (ram_rdata),
    .key_table_i (item_q.tgt_table),
    .key_addr_i  (item_q.addr),
    .now_i       (item_q.now_s),
    .max_age_i   (max_age_q),
    .res_o       (scan),
    .expire_o    (expire)
  );

  // decision helpers
  logic             own_ship, take_new, has_free, evict_ok;
  logic [IDX_W-1:0] free_idx;
  logic [31:0]      dt_new;
  logic [CNT_W-1:0] occ;

  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = CAP - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        has_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    occ = '0;
    for (int i = 0; i < CAP; i++) begin
      occ = occ + CNT_W'(used_q[i]);
    end
  end

  assign own_ship = (own_addr_q != '0) && (item_q.tgt_table == own_table_q)
                    && ((item_q.addr[23:0] & ttt_pkg::ADDR_LOW_MASK) == own_addr_q);
  assign dt_new   = item_q.obs_time_s - scan.match_time;

  always_comb begin
    // a lower rank is held off shortly after a better one
    if (item_q.src_rank < scan.match_rank && item_q.obs_time_s >= scan.match_time
        && dt_new <= 32'(hold_q)) begin
      take_new = 1'b0;
    end else if (item_q.obs_time_s != scan.match_time) begin
      take_new = item_q.obs_time_s > scan.match_time;
    end else begin
      take_new = item_q.src_rank >= scan.match_rank;
    end
  end

  assign evict_ok = scan.best_found && ttt_pkg::less_important(
      scan.best_slant, scan.best_rank, scan.best_age,
      item_q.slant_m, item_q.src_rank, item_q.now_s - item_q.obs_time_s);

  assign s_axis_tready = (state_q == ttt_pkg::S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    used_d     = used_q;
    alarm_d    = alarm_q;
    refusals_d = refusals_q;
    cnt_d      = cnt_q;
    proc_vld_d = 1'b0;
    proc_idx_d = proc_idx_q;
    removed_d  = removed_q;
    status_d   = status_q;
    slot_res_d = slot_res_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_user_d = out_user_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = cnt_q[IDX_W-1:0];
    scan_clear = 1'b0;

    unique case (state_q)
      ttt_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          item_d = ttt_pkg::item_t'({s_axis_tuser, s_axis_tdata});
          // no own reference counts as zero range
          if (ttt_pkg::plaus_e'(s_axis_tdata[107:106]) == ttt_pkg::PL_NO_REF) begin
            item_d.slant_m = '0;
          end
          cnt_d      = '0;
          removed_d  = '0;
          scan_clear = 1'b1;
          if (ttt_pkg::op_e'(s_axis_tuser) == ttt_pkg::OP_OBSERVE
              || ttt_pkg::op_e'(s_axis_tuser) == ttt_pkg::OP_AGE_OUT) begin
            state_d = ttt_pkg::S_SCAN;
          end else begin
            state_d = ttt_pkg::S_DECIDE;
          end
        end
      end
      ttt_pkg::S_SCAN: begin
        // read one slot a cycle, data judged in the cycle after
        if (cnt_q < CNT_W'(CAP)) begin
          ram_re     = 1'b1;
          proc_vld_d = 1'b1;
          proc_idx_d = cnt_q[IDX_W-1:0];
          cnt_d      = cnt_q + 1'b1;
        end else if (!proc_vld_q) begin
          state_d = ttt_pkg::S_DECIDE;
        end
        if (expire && item_q.op == ttt_pkg::OP_AGE_OUT) begin
          used_d[proc_idx_q]  = 1'b0;
          alarm_d[proc_idx_q] = 1'b0;
          removed_d           = removed_q + 1'b1;
        end
      end
      ttt_pkg::S_DECIDE: begin
        status_d   = ttt_pkg::ST_OTHER_DONE;
        slot_res_d = '0;
        ram_wdata  = '{key_table: item_q.tgt_table, key_addr: item_q.addr,
                       time_s: item_q.obs_time_s, rank: item_q.src_rank,
                       slant: item_q.slant_m};
        unique case (item_q.op)
          ttt_pkg::OP_OBSERVE: begin
            if (own_ship) begin
              status_d = ttt_pkg::ST_OWN_SHIP;
            end else if (ttt_pkg::plaus_e'(item_q.plausibility) == ttt_pkg::PL_TOO_FAR) begin
              status_d   = ttt_pkg::ST_IMPLAUSIBLE;
              refusals_d = refusals_q + 1'b1;
            end else if (scan.match_found) begin
              slot_res_d = scan.match_idx;
              if (take_new) begin
                status_d  = ttt_pkg::ST_UPDATED;
                ram_we    = 1'b1;
                ram_waddr = scan.match_idx;
              end else begin
                status_d = ttt_pkg::ST_KEPT_OLDER;
              end
            end else if (has_free || evict_ok) begin
              status_d           = ttt_pkg::ST_INSERTED;
              slot_res_d         = has_free ? free_idx : scan.best_idx;
              ram_we             = 1'b1;
              ram_waddr          = slot_res_d;
              used_d[slot_res_d] = 1'b1;
              alarm_d[slot_res_d] = 1'b0;
            end else begin
              status_d = ttt_pkg::ST_FULL;
            end
          end
          ttt_pkg::OP_AGE_OUT: ;
          ttt_pkg::OP_ALARM: begin
            if (32'(item_q.slot) < 32'(CAP)) begin
              alarm_d[IDX_W'(item_q.slot)] = item_q.alarm_mark;
            end
          end
          ttt_pkg::OP_CLEAR: begin
            used_d  = '0;
            alarm_d = '0;
          end
          default: ;
        endcase
        state_d = ttt_pkg::S_FINISH;
      end
      ttt_pkg::S_FINISH: begin
        // result register takes the transaction when free
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_user_d = status_q;
          out_data_d = {2'b00, refusals_q, 5'(removed_q), 5'(occ), 4'(slot_res_q)};
          state_d    = ttt_pkg::S_IDLE;
        end
      end
      default: state_d = ttt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ttt_pkg::S_IDLE;
      used_q     <= '0;
      alarm_q    <= '0;
      refusals_q <= '0;
      cnt_q      <= '0;
      proc_vld_q <= 1'b0;
      removed_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      alarm_q    <= alarm_d;
      refusals_q <= refusals_d;
      cnt_q      <= cnt_d;
      proc_vld_q <= proc_vld_d;
      removed_q  <= removed_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    proc_idx_q <= proc_idx_d;
    status_q   <= status_d;
    slot_res_q <= slot_res_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
`default_nettype wire
